// File: hw/rtl/ascii_stl_record_scanner_macros.svh
// assertion helpers for the record scanner
`ifndef ASCII_STL_RECORD_SCANNER_MACROS_SVH
`define ASCII_STL_RECORD_SCANNER_MACROS_SVH

// condition in the same cycle
`define ASR_ASSERT_IMPLY(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// condition in the following cycle
`define ASR_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// File: hw/rtl/asr_pkg.sv
package asr_pkg;

	// longest line accepted before the overlong error
	localparam int MAX_LINE_BYTES = 16384;
	localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1);

	// counter widths
	localparam int FCNT_W = 33;
	localparam int VCNT_W = 34;
	localparam int LIM_W = 34;
	localparam int DIFF_W = 36;
	localparam int KW_W = 3;

	localparam logic [31:0] MAX_TRI_RESET = 32'd1048576;
	localparam logic [LIM_W-1:0] LIM3_RESET = 34'd3145728;

	localparam logic [7:0] ASCII_LF = 8'h0A;

	// keyword lengths and the position where the match window closes
	localparam logic [KW_W-1:0] FACET_LEN = 3'd5;
	localparam logic [KW_W-1:0] VERTEX_LEN = 3'd6;
	localparam logic [KW_W-1:0] KW_END = 3'd7;

	// status codes
	localparam logic [2:0] ST_SCAN = 3'd0;
	localparam logic [2:0] ST_OK = 3'd1;
	localparam logic [2:0] ST_LONG = 3'd2;
	localparam logic [2:0] ST_FACET = 3'd3;
	localparam logic [2:0] ST_VERTEX = 3'd4;
	localparam logic [2:0] ST_NONE = 3'd5;
	localparam logic [2:0] ST_MISMATCH = 3'd6;

	// prefix phase of the current line
	typedef enum logic [2:0] {
		PH_LEAD = 3'b001,
		PH_WORD = 3'b010,
		PH_REST = 3'b100
	} phase_t;

	// what one transaction did to the line
	typedef struct packed {
		logic facet;
		logic vertex;
		logic overlong;
	} scan_rec_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] facet_char(input logic [KW_W-1:0] p);
		logic [7:0] c;
		case (p)
			3'd0: c = 8'h66;
			3'd1: c = 8'h61;
			3'd2: c = 8'h63;
			3'd3: c = 8'h65;
			3'd4: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] vertex_char(input logic [KW_W-1:0] p);
		logic [7:0] c;
		case (p)
			3'd0: c = 8'h76;
			3'd1: c = 8'h65;
			3'd2: c = 8'h72;
			3'd3: c = 8'h74;
			3'd4: c = 8'h65;
			3'd5: c = 8'h78;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/asr_line_scan.sv
module asr_line_scan
	import asr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       last,
	input  logic       busy,
	input  logic [7:0] data,
	output scan_rec_t  rec
);

	logic [LEN_W-1:0] len_q;
	phase_t           phase_q;
	logic [KW_W-1:0]  kpos_q;
	logic             fposs_q;
	logic             vposs_q;

	phase_t           phase_f;
	logic [KW_W-1:0]  kpos_f;
	logic             fposs_f;
	logic             vposs_f;

	phase_t           ev_phase;
	logic [KW_W-1:0]  ev_kpos;
	logic             ev_f;
	logic             ev_v;

	logic             is_lf;
	logic             at_max;
	logic             ws;
	logic             in_word;
	logic [7:0]       lc;
	logic             finish;
	logic             started;
	logic             facet_hit;
	logic             vertex_hit;

	// line state after taking this byte as an ordinary character
	always_comb begin
		is_lf = data == ASCII_LF;
		at_max = len_q >= LEN_W'(MAX_LINE_BYTES);
		ws = is_ws(data);
		lc = to_lower(data);
		phase_f = phase_q;
		kpos_f = kpos_q;
		fposs_f = fposs_q;
		vposs_f = vposs_q;
		unique case (phase_q)
			PH_LEAD: in_word = !ws;
			PH_WORD: in_word = 1'b1;
			PH_REST: in_word = 1'b0;
			default: in_word = 1'b0;
		endcase
		if (in_word) begin
			if (kpos_q < FACET_LEN) begin
				fposs_f = fposs_q && (lc == facet_char(kpos_q));
			end else if (kpos_q == FACET_LEN) begin
				fposs_f = fposs_q && ws;
			end
			if (kpos_q < VERTEX_LEN) begin
				vposs_f = vposs_q && (lc == vertex_char(kpos_q));
			end else if (kpos_q == VERTEX_LEN) begin
				vposs_f = vposs_q && ws;
			end
			kpos_f = kpos_q + KW_W'(1);
			if (kpos_f == KW_END || (!fposs_f && !vposs_f)) begin
				phase_f = PH_REST;
			end else begin
				phase_f = PH_WORD;
			end
		end
	end

	// line to judge: the held one at a line feed, else the one just extended
	always_comb begin
		if (is_lf) begin
			ev_phase = phase_q;
			ev_kpos = kpos_q;
			ev_f = fposs_q;
			ev_v = vposs_q;
		end else begin
			ev_phase = phase_f;
			ev_kpos = kpos_f;
			ev_f = fposs_f;
			ev_v = vposs_f;
		end
		finish = fire && busy && (is_lf || (last && !at_max));
		started = ev_phase != PH_LEAD;
		facet_hit = started && ev_f && (ev_kpos >= FACET_LEN);
		vertex_hit = started && ev_v && (ev_kpos >= VERTEX_LEN);
		rec.facet = finish && facet_hit;
		rec.vertex = finish && !facet_hit && vertex_hit;
		rec.overlong = fire && busy && !is_lf && at_max;
	end

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			phase_q <= PH_LEAD;
			kpos_q <= '0;
			fposs_q <= 1'b1;
			vposs_q <= 1'b1;
		end else if (fire) begin
			if (last || (busy && is_lf)) begin
				len_q <= '0;
				phase_q <= PH_LEAD;
				kpos_q <= '0;
				fposs_q <= 1'b1;
				vposs_q <= 1'b1;
			end else if (busy && !at_max) begin
				len_q <= len_q + LEN_W'(1);
				phase_q <= phase_f;
				kpos_q <= kpos_f;
				fposs_q <= fposs_f;
				vposs_q <= vposs_f;
			end
		end
	end

endmodule

// File: hw/rtl/asr_record_count.sv
module asr_record_count
	import asr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              last,
	input  scan_rec_t         rec,
	input  logic [31:0]       max_tri,
	input  logic [LIM_W-1:0]  lim3,
	output logic              busy,
	output logic [2:0]        status,
	output logic [31:0]       facet_total,
	output logic [VCNT_W-1:0] vertex_total
);

	logic [FCNT_W-1:0] facet_q;
	logic [FCNT_W-1:0] facet_d;
	logic [VCNT_W-1:0] vertex_q;
	logic [VCNT_W-1:0] vertex_d;
	// vertex count minus three times facet count, kept running
	logic [DIFF_W-1:0] diff_q;
	logic [DIFF_W-1:0] diff_d;
	logic [2:0]        err_q;
	logic [2:0]        err_a;
	logic [2:0]        err_fin;
	logic              no_facets;
	logic              over_lim;
	logic              mismatch;

	// counts, limit checks and end-of-file checks
	always_comb begin
		busy = err_q == ST_SCAN;
		facet_d = facet_q + FCNT_W'(rec.facet);
		vertex_d = vertex_q + VCNT_W'(rec.vertex);
		if (rec.facet) begin
			diff_d = diff_q - DIFF_W'(3);
		end else if (rec.vertex) begin
			diff_d = diff_q + DIFF_W'(1);
		end else begin
			diff_d = diff_q;
		end

		// count plus one above the limit is count at or above it
		err_a = err_q;
		if (rec.overlong) begin
			err_a = ST_LONG;
		end else if (rec.facet && facet_q >= {1'b0, max_tri}) begin
			err_a = ST_FACET;
		end else if (rec.vertex && vertex_q >= lim3) begin
			err_a = ST_VERTEX;
		end

		no_facets = (facet_q == '0) && !rec.facet;
		over_lim = !rec.facet && (facet_q > {1'b0, max_tri});
		if (rec.facet) begin
			mismatch = diff_q != DIFF_W'(3);
		end else if (rec.vertex) begin
			mismatch = diff_q != '1;
		end else begin
			mismatch = diff_q != '0;
		end

		err_fin = err_a;
		if (err_a == ST_SCAN) begin
			if (no_facets) begin
				err_fin = ST_NONE;
			end else if (over_lim) begin
				err_fin = ST_FACET;
			end else if (mismatch) begin
				err_fin = ST_MISMATCH;
			end
		end

		if (last) begin
			status = (err_fin == ST_SCAN) ? ST_OK : err_fin;
		end else begin
			status = err_a;
		end
		facet_total = facet_d[FCNT_W-1] ? '1 : facet_d[31:0];
		vertex_total = vertex_d;
	end

	// file state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			facet_q <= '0;
			vertex_q <= '0;
			diff_q <= '0;
			err_q <= ST_SCAN;
		end else if (fire) begin
			if (last) begin
				facet_q <= '0;
				vertex_q <= '0;
				diff_q <= '0;
				err_q <= ST_SCAN;
			end else begin
				facet_q <= facet_d;
				vertex_q <= vertex_d;
				diff_q <= diff_d;
				err_q <= err_a;
			end
		end
	end

endmodule

// File: hw/rtl/ascii_stl_record_scanner.sv
// Byte-serial scanner for text mesh files. Input channel: one file byte per
// transaction on data_byte, with last_byte set on the final byte of a file.
// Output channel: one result transaction per input byte, giving scan_status
// (0 scanning, 1 done ok, 2..6 error codes) and the facet and vertex record
// counts so far. Both channels use valid/stall; a transaction moves at a clock
// edge with valid high and stall low.
// From the input transaction to the earliest result transaction a byte passes through
// the input register and then the result register.
// Throughput is one byte per cycle while the output does not stall, set by the single
// scan stage that updates line and count state.
// An output stall holds the result register; an empty input stage still takes
// one byte, and input stall stays high while both stages are full and the
// output stalls.
// The user must write the facet limit through cfg_write/cfg_data while the block is idle;
// the block does not enforce this. The vertex limit, three times that value, is formed at the write.
// arst_n clears the line state, counts, errors and both stages, and sets the
// facet limit to 1048576. After a last byte all file state starts over.
`include "ascii_stl_record_scanner_macros.svh"

module ascii_stl_record_scanner
	import asr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        scan_status,
	output logic [31:0]       facet_total,
	output logic [VCNT_W-1:0] vertex_total
);

	logic [31:0]       max_q;
	logic [LIM_W-1:0]  lim3_q;

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;

	logic              valid_s2;
	logic [2:0]        status_s2;
	logic [31:0]       facet_s2;
	logic [VCNT_W-1:0] vertex_s2;

	logic              advance;
	logic              fire;
	logic              busy;
	scan_rec_t         rec;
	logic [2:0]        status_c;
	logic [31:0]       facet_c;
	logic [VCNT_W-1:0] vertex_c;

	// limit register and its tripled copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_TRI_RESET;
			lim3_q <= LIM3_RESET;
		end else if (cfg_write) begin
			max_q <= cfg_data;
			lim3_q <= {2'b00, cfg_data} + {1'b0, cfg_data, 1'b0};
		end
	end

	// handshake between the stages
	assign advance = !valid_s2 || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	asr_line_scan u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.last   (last_s1),
		.busy   (busy),
		.data   (data_s1),
		.rec    (rec)
	);

	asr_record_count u_count (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.last         (last_s1),
		.rec          (rec),
		.max_tri      (max_q),
		.lim3         (lim3_q),
		.busy         (busy),
		.status       (status_c),
		.facet_total  (facet_c),
		.vertex_total (vertex_c)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_c;
			facet_s2 <= facet_c;
			vertex_s2 <= vertex_c;
		end
	end

	assign out_valid = valid_s2;
	assign scan_status = status_s2;
	assign facet_total = facet_s2;
	assign vertex_total = vertex_s2;

	// checks
	`ASR_ASSERT_IMPLY(a_stall_only_full, in_stall, valid_s1,
		"input stall raised with an empty input stage")
	`ASR_ASSERT_NEXT(a_last_has_verdict, fire && last_s1, status_s2 != ST_SCAN,
		"last byte produced a scanning status")
	`ASR_ASSERT_IMPLY(a_facet_err_count, valid_s2 && status_s2 == ST_FACET, facet_s2 != '0,
		"facet limit reported with zero facets")

endmodule
